// ===== hw/rtl/serial_bank_mapper_top_defines.svh =====
// ---------------------------------------------------------------------------
// Serial bank mapper assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef SERIAL_BANK_MAPPER_TOP_DEFINES_SVH
`define SERIAL_BANK_MAPPER_TOP_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define SBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define SBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sbm_pkg.sv =====
// ---------------------------------------------------------------------------
// Serial bank mapper package
// Shared types, register codes and constants of the serial bank mapper.
// ---------------------------------------------------------------------------
package sbm_pkg;

    // Field widths.
    localparam int AddrW  = 16;
    localparam int DataW  = 8;
    localparam int PrgW   = 19;
    localparam int ChrW   = 17;
    localparam int MirW   = 2;
    localparam int RegW   = 5;
    localparam int CountW = 6;

    // Offset granularity: 16 KB program banks, 4 KB character halves.
    localparam int PrgBankBits = 14;
    localparam int ChrHalfBits = 12;

    // Serial register holds five bits before a load.
    localparam logic [2:0] ShiftLen = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_CHR_ROM_PRESENT = 1'b0;
    localparam logic CFG_PRG_BANK_COUNT  = 1'b1;

    // Configuration reset values.
    localparam logic              ChrPresentRst = 1'b1;
    localparam logic [CountW-1:0] PrgCountRst   = 6'd8;
    localparam logic [CountW-1:0] PrgCountOuter = 6'd32;

    // Target register select, from address bits 14..13.
    localparam logic [1:0] SEL_CONTROL = 2'd0;
    localparam logic [1:0] SEL_CHR_A   = 2'd1;
    localparam logic [1:0] SEL_CHR_B   = 2'd2;
    localparam logic [1:0] SEL_PRG     = 2'd3;

    // Control register reset value and single-screen mirroring code.
    localparam logic [RegW-1:0] ControlRst   = 5'h04;
    localparam logic [MirW-1:0] MIRROR_SINGLE = 2'd2;

    // A completed serial load headed for one register.
    typedef struct packed {
        logic            valid;
        logic [1:0]      sel;
        logic [RegW-1:0] value;
    } t_load;

    // Window bases and mirroring reported with each item.
    typedef struct packed {
        logic [MirW-1:0] mirror;
        logic [ChrW-1:0] chr_high;
        logic [ChrW-1:0] chr_low;
        logic [PrgW-1:0] prg_high;
        logic [PrgW-1:0] prg_low;
    } t_bases;

    // Offset of the last 16 KB program bank, wrapped to the program width.
    function automatic logic [PrgW-1:0] last_bank_base(input logic [CountW-1:0] count);
        logic [CountW-1:0] last;
        last = count - 6'd1;
        return {last[PrgW-PrgBankBits-1:0], {PrgBankBits{1'b0}}};
    endfunction

endpackage

// ===== hw/rtl/sbm_shift.sv =====
// ---------------------------------------------------------------------------
// Serial bank mapper shift register
// Collects data bit 0 of mapper writes, LSB first, and issues a load on the
// fifth bit. A write with data bit 7 set clears the collected bits.
// ---------------------------------------------------------------------------
`include "serial_bank_mapper_top_defines.svh"

module sbm_shift (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic [sbm_pkg::AddrW-1:0] i_addr,
    input  logic [sbm_pkg::DataW-1:0] i_data,
    output sbm_pkg::t_load           o_load
);

    logic [2:0]               r_count;
    logic [2:0]               n_count;
    logic [sbm_pkg::RegW-1:0] r_value;
    logic [sbm_pkg::RegW-1:0] n_value;

    logic                     w_mapped;
    logic                     w_clear;
    logic                     w_shift;
    logic [2:0]               w_count_inc;
    logic [sbm_pkg::RegW-1:0] w_value_shift;

    // Decode the write and form the shifted value.
    always_comb begin
        w_mapped      = i_addr[sbm_pkg::AddrW-1];
        w_clear       = i_step && w_mapped && i_data[7];
        w_shift       = i_step && w_mapped && !i_data[7];
        w_count_inc   = r_count + 3'd1;
        w_value_shift = r_value | ({{(sbm_pkg::RegW-1){1'b0}}, i_data[0]} << r_count);
    end

    // A load leaves on the fifth bit.
    always_comb begin
        o_load.valid = w_shift && (w_count_inc == sbm_pkg::ShiftLen);
        o_load.sel   = i_addr[14:13];
        o_load.value = w_value_shift;
    end

    // Next shift state.
    always_comb begin
        n_count = r_count;
        n_value = r_value;
        if (w_clear || o_load.valid) begin
            n_count = 3'd0;
            n_value = '0;
        end else if (w_shift) begin
            n_count = w_count_inc;
            n_value = w_value_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
            r_value <= '0;
        end else begin
            r_count <= n_count;
            r_value <= n_value;
        end
    end

    // The count never reaches five; a load resets it at that point.
    `SBM_ASSERT(a_count_range, r_count < sbm_pkg::ShiftLen, "shift count out of range")
    // A load only follows four stored bits.
    `SBM_ASSERT(a_load_after_four, !o_load.valid || (r_count == 3'd4), "load before fifth bit")
    // After a load the shift register starts empty.
    `SBM_ASSERT_NEXT(a_load_empties, o_load.valid, (r_count == 3'd0) && (r_value == '0),
        "shift register not emptied after load")
    // A clear write empties the shift register.
    `SBM_ASSERT_NEXT(a_clear_empties, w_clear, (r_count == 3'd0) && (r_value == '0),
        "shift register not emptied by clear write")

endmodule

// ===== hw/rtl/sbm_banks.sv =====
// ---------------------------------------------------------------------------
// Serial bank mapper bank registers
// Holds the four mapper registers and the configuration, recomputes the window
// bases and the mirroring on each load, and sets the program high base on a bank-count write.
// ---------------------------------------------------------------------------
module sbm_banks (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [sbm_pkg::CountW-1:0] i_cfg_data,
    input  sbm_pkg::t_load             i_load,
    output sbm_pkg::t_bases            o_bases
);

    logic                       r_chr_present, n_chr_present;
    logic [sbm_pkg::CountW-1:0] r_prg_count,   n_prg_count;
    logic [sbm_pkg::RegW-1:0]   r_control,     n_control;
    logic [sbm_pkg::RegW-1:0]   r_chr_a,       n_chr_a;
    logic [sbm_pkg::RegW-1:0]   r_chr_b,       n_chr_b;
    logic [sbm_pkg::RegW-1:0]   r_prg_bank,    n_prg_bank;
    sbm_pkg::t_bases            r_bases,       n_bases;

    logic w_outer;

    // Register writes, then the window recompute from the new values.
    always_comb begin
        n_chr_present = r_chr_present;
        n_prg_count   = r_prg_count;
        n_control     = r_control;
        n_chr_a       = r_chr_a;
        n_chr_b       = r_chr_b;
        n_prg_bank    = r_prg_bank;
        n_bases       = r_bases;
        w_outer       = 1'b0;

        if (i_load.valid) begin
            case (i_load.sel)
                sbm_pkg::SEL_CONTROL: n_control  = i_load.value;
                sbm_pkg::SEL_CHR_A:   n_chr_a    = i_load.value;
                sbm_pkg::SEL_CHR_B:   n_chr_b    = i_load.value;
                sbm_pkg::SEL_PRG:     n_prg_bank = i_load.value;
                default:              n_prg_bank = i_load.value;
            endcase

            n_bases.mirror = n_control[1] ? {1'b0, n_control[0]} : sbm_pkg::MIRROR_SINGLE;

            // Character windows switch only with character ROM.
            if (r_chr_present) begin
                if (!n_control[4]) begin
                    n_bases.chr_low  = {n_chr_a[3:0], 1'b0, {sbm_pkg::ChrHalfBits{1'b0}}};
                    n_bases.chr_high = {n_chr_a[3:0], 1'b1, {sbm_pkg::ChrHalfBits{1'b0}}};
                end else begin
                    n_bases.chr_low  = {1'b0, n_chr_a[3:0], {sbm_pkg::ChrHalfBits{1'b0}}};
                    n_bases.chr_high = {1'b0, n_chr_b[3:0], {sbm_pkg::ChrHalfBits{1'b0}}};
                end
            end else begin
                w_outer = (r_prg_count == sbm_pkg::PrgCountOuter) && n_chr_a[4];
            end

            // Program windows: 32 KB pair or one 16 KB window.
            if (!n_control[3]) begin
                n_bases.prg_low  = {w_outer, n_prg_bank[3:1], 1'b0,
                                    {sbm_pkg::PrgBankBits{1'b0}}};
                n_bases.prg_high = {w_outer, n_prg_bank[3:1], 1'b1,
                                    {sbm_pkg::PrgBankBits{1'b0}}};
            end else if (n_control[2]) begin
                n_bases.prg_low  = {w_outer, n_prg_bank[3:0], {sbm_pkg::PrgBankBits{1'b0}}};
            end else begin
                n_bases.prg_high = {w_outer, n_prg_bank[3:0], {sbm_pkg::PrgBankBits{1'b0}}};
            end
        end

        // Configuration writes must arrive only while no item is in flight; the block itself does not enforce this.
        if (i_cfg_we) begin
            case (i_cfg_index)
                sbm_pkg::CFG_CHR_ROM_PRESENT: n_chr_present = i_cfg_data[0];
                sbm_pkg::CFG_PRG_BANK_COUNT: begin
                    n_prg_count      = i_cfg_data;
                    n_bases.prg_high = sbm_pkg::last_bank_base(i_cfg_data);
                end
                default: n_chr_present = r_chr_present;
            endcase
        end
    end

    // The reported bases are those after this item's update.
    assign o_bases = n_bases;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chr_present    <= sbm_pkg::ChrPresentRst;
            r_prg_count      <= sbm_pkg::PrgCountRst;
            r_control        <= sbm_pkg::ControlRst;
            r_chr_a          <= '0;
            r_chr_b          <= '0;
            r_prg_bank       <= '0;
            r_bases.mirror   <= '0;
            r_bases.chr_high <= '0;
            r_bases.chr_low  <= '0;
            r_bases.prg_high <= sbm_pkg::last_bank_base(sbm_pkg::PrgCountRst);
            r_bases.prg_low  <= '0;
        end else begin
            r_chr_present <= n_chr_present;
            r_prg_count   <= n_prg_count;
            r_control     <= n_control;
            r_chr_a       <= n_chr_a;
            r_chr_b       <= n_chr_b;
            r_prg_bank    <= n_prg_bank;
            r_bases       <= n_bases;
        end
    end

endmodule

// ===== hw/rtl/serial_bank_mapper_top.sv =====
// Path: an accepted item sits in the input register, then moves to the result
// register once that register is free or being emptied.
// Throughput: one item per cycle while the receiver accepts results; the shift
// and bank logic between the two registers is combinational.
// Reset: synchronous, active low; clears both stage valids, the shift register,
// the mapper registers and the configuration to their power-up values.
// ---------------------------------------------------------------------------
// Serial bank mapper top level
// Stream wrapper: input register, serial shift and bank logic, result register.
// ---------------------------------------------------------------------------
module serial_bank_mapper_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // address[15:0], write_data[23:16]
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // prg_low_base[18:0], prg_high_base[37:19],
                                        // chr_low_base[54:38], chr_high_base[71:55],
                                        // mirror_mode[73:72], regs_loaded[74], zero
);

    logic                      r_in_valid;
    logic [sbm_pkg::AddrW-1:0] r_in_addr;
    logic [sbm_pkg::DataW-1:0] r_in_data;
    logic                      r_out_valid;
    sbm_pkg::t_bases           r_out_bases;
    logic                      r_out_loaded;

    logic                      w_advance;
    sbm_pkg::t_load            w_load;
    sbm_pkg::t_bases           w_bases;

    // An item moves on when the result register is free or being emptied.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_addr <= s_axis_tdata[15:0];
            r_in_data <= s_axis_tdata[23:16];
        end
        if (w_advance) begin
            r_out_bases  <= w_bases;
            r_out_loaded <= w_load.valid;
        end
    end

    sbm_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_addr  (r_in_addr),
        .i_data  (r_in_data),
        .o_load  (w_load)
    );

    sbm_banks u_banks (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_load      (w_load),
        .o_bases     (w_bases)
    );

    // Result item packing.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_loaded, r_out_bases.mirror,
                            r_out_bases.chr_high, r_out_bases.chr_low,
                            r_out_bases.prg_high, r_out_bases.prg_low};

endmodule

// ===== tb/serial_bank_mapper_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Serial bank mapper testbench
// Drives CPU write items into the mapper under several configurations and
// idle patterns. A scoreboard predicts the window bases for every write and
// checks each result item field by field, in order.
// ---------------------------------------------------------------------------
module serial_bank_mapper_top_test;

    // Address decode, offsets and run shape.
    localparam logic [sbm_pkg::AddrW-1:0] MapperBase = 16'h8000;
    localparam logic [31:0]      PrgBankSize = 32'h4000;
    localparam logic [31:0]      ChrHalfSize = 32'h1000;
    localparam logic [31:0]      OuterOffset = 32'h40000;
    localparam int               PhaseCount  = 8;
    localparam int               PhaseItems  = 232;
    localparam int               TailCycles  = 4;
    localparam int               WatchdogNs  = 5_000_000;

    // One result item as the scoreboard holds it; matches tdata[74:0].
    typedef struct packed {
        logic            loaded;
        sbm_pkg::t_bases bases;
    } t_mapper_view;

    // Scoreboard: tracks the mapper state and the window bases still owed.
    class window_checker;
        logic                       chr_present;
        logic [sbm_pkg::CountW-1:0] bank_count;
        logic [2:0]                 shift_cnt;
        logic [sbm_pkg::RegW-1:0]   shift_val;
        logic [sbm_pkg::RegW-1:0]   control;
        logic [sbm_pkg::RegW-1:0]   chr_a;
        logic [sbm_pkg::RegW-1:0]   chr_b;
        logic [sbm_pkg::RegW-1:0]   prg_reg;
        sbm_pkg::t_bases            win;
        t_mapper_view               expected_views[$];
        int                         errors;

        function new();
            chr_present = sbm_pkg::ChrPresentRst;
            bank_count  = sbm_pkg::PrgCountRst;
            shift_cnt   = '0;
            shift_val   = '0;
            control     = sbm_pkg::ControlRst;
            chr_a       = '0;
            chr_b       = '0;
            prg_reg     = '0;
            win         = '0;
            win.prg_high = last_base();
            errors      = 0;
        endfunction

        // Offset of the last program bank, wrapped to the program width.
        function logic [sbm_pkg::PrgW-1:0] last_base();
            logic [31:0] last;
            last = 32'(bank_count) - 32'd1;
            return sbm_pkg::PrgW'(last * PrgBankSize);
        endfunction

        function void write_cfg(logic idx, logic [sbm_pkg::CountW-1:0] value);
            if (idx == sbm_pkg::CFG_CHR_ROM_PRESENT) begin
                chr_present = value[0];
            end else begin
                bank_count   = value;
                win.prg_high = last_base();
            end
        endfunction

        // Rebuild mirroring and the window bases after a register load.
        function void reload_windows();
            logic [31:0] outer;
            logic [31:0] base;
            outer = '0;
            win.mirror = control[1] ? {1'b0, control[0]} : sbm_pkg::MIRROR_SINGLE;
            if (chr_present) begin
                if (!control[4]) begin
                    win.chr_low  = sbm_pkg::ChrW'(32'(chr_a[3:0]) * 2 * ChrHalfSize);
                    win.chr_high = win.chr_low + sbm_pkg::ChrW'(ChrHalfSize);
                end else begin
                    win.chr_low  = sbm_pkg::ChrW'(32'(chr_a[3:0]) * ChrHalfSize);
                    win.chr_high = sbm_pkg::ChrW'(32'(chr_b[3:0]) * ChrHalfSize);
                end
            end else if (bank_count == sbm_pkg::PrgCountOuter && chr_a[4]) begin
                outer = OuterOffset;
            end
            if (!control[3]) begin
                // 32 KB mode: both windows follow the even bank.
                base = outer + 32'(prg_reg & 5'h0E) * PrgBankSize;
                win.prg_low  = sbm_pkg::PrgW'(base);
                win.prg_high = sbm_pkg::PrgW'(base + PrgBankSize);
            end else begin
                // 16 KB mode: only the selected window moves.
                base = outer + 32'(prg_reg[3:0]) * PrgBankSize;
                if (control[2]) begin
                    win.prg_low = sbm_pkg::PrgW'(base);
                end else begin
                    win.prg_high = sbm_pkg::PrgW'(base);
                end
            end
        endfunction

        // Predict the result of one accepted write item.
        function void note_write(logic [sbm_pkg::AddrW-1:0] addr,
                                 logic [sbm_pkg::DataW-1:0] data);
            t_mapper_view v;
            v.loaded = 1'b0;
            if (addr >= MapperBase) begin
                if (data[7]) begin
                    shift_cnt = '0;
                    shift_val = '0;
                end else begin
                    shift_val = shift_val | (sbm_pkg::RegW'(data[0]) << shift_cnt);
                    shift_cnt = shift_cnt + 3'd1;
                    if (shift_cnt >= sbm_pkg::ShiftLen) begin
                        case (addr[14:13])
                            sbm_pkg::SEL_CONTROL: control = shift_val;
                            sbm_pkg::SEL_CHR_A:   chr_a   = shift_val;
                            sbm_pkg::SEL_CHR_B:   chr_b   = shift_val;
                            default:              prg_reg = shift_val;
                        endcase
                        shift_cnt = '0;
                        shift_val = '0;
                        v.loaded  = 1'b1;
                        reload_windows();
                    end
                end
            end
            v.bases = win;
            expected_views.push_back(v);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Check one result item against the oldest prediction.
        function void check_view(logic [79:0] tdata);
            t_mapper_view got;
            t_mapper_view want;
            got = tdata[74:0];
            if (expected_views.size() == 0) begin
                $display("%0t: result item with nothing expected, actual %h", $time, tdata);
                errors++;
                return;
            end
            want = expected_views.pop_front();
            compare_field("prg_low_base", 32'(want.bases.prg_low), 32'(got.bases.prg_low));
            compare_field("prg_high_base", 32'(want.bases.prg_high), 32'(got.bases.prg_high));
            compare_field("chr_low_base", 32'(want.bases.chr_low), 32'(got.bases.chr_low));
            compare_field("chr_high_base", 32'(want.bases.chr_high), 32'(got.bases.chr_high));
            compare_field("mirror_mode", 32'(want.bases.mirror), 32'(got.bases.mirror));
            compare_field("regs_loaded", 32'(want.loaded), 32'(got.loaded));
            compare_field("padding", 32'd0, 32'(tdata[79:75]));
        endfunction

        function int pending();
            return expected_views.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [5:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;

    window_checker sb;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;

    serial_bank_mapper_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog for a hung run.
    initial begin
        #(WatchdogNs);
        $display("serial_bank_mapper_top_test: errors");
        $finish;
    end

    // Receiver: random back-pressure, updated at the falling edge.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Result checking at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_view(m_axis_tdata);
        end
    end

    // Send one write item; entered and left at a falling edge.
    task automatic send_write(logic [sbm_pkg::AddrW-1:0] addr,
                              logic [sbm_pkg::DataW-1:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {data, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_write(addr, data);
        @(negedge i_clk);
    endtask

    // Five serial writes that load one register; the last address picks it.
    task automatic send_load(logic [sbm_pkg::AddrW-1:0] addr,
                             logic [sbm_pkg::RegW-1:0] value, bit scramble);
        logic [sbm_pkg::AddrW-1:0] a;
        logic [sbm_pkg::DataW-1:0] d;
        for (int i = 0; i < 5; i++) begin
            a = (scramble && i < 4) ? (MapperBase | 16'($urandom_range(0, 16'h7FFF))) : addr;
            d = scramble ? {1'b0, 6'($urandom_range(0, 63)), value[i]} : {7'd0, value[i]};
            send_write(a, d);
        end
    endtask

    // Hold the sender off until every predicted result has arrived.
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // Write both configuration registers while the mapper is idle.
    task automatic apply_settings(logic present, logic [sbm_pkg::CountW-1:0] count);
        drain_results();
        repeat (TailCycles) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = sbm_pkg::CFG_CHR_ROM_PRESENT;
        i_cfg_data  = {5'd0, present};
        @(posedge i_clk);
        sb.write_cfg(sbm_pkg::CFG_CHR_ROM_PRESENT, {5'd0, present});
        @(negedge i_clk);
        i_cfg_index = sbm_pkg::CFG_PRG_BANK_COUNT;
        i_cfg_data  = count;
        @(posedge i_clk);
        sb.write_cfg(sbm_pkg::CFG_PRG_BANK_COUNT, count);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Main stimulus.
    initial begin : stimulus
        int                         sent;
        int                         kind;
        logic [sbm_pkg::AddrW-1:0]  addr;
        logic [sbm_pkg::DataW-1:0]  data;
        logic                       cfg_present;
        logic [sbm_pkg::CountW-1:0] cfg_count;

        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = sbm_pkg::CFG_CHR_ROM_PRESENT;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: low address, a partial load cut by a clear, then full loads.
        send_write(16'h7FFF, 8'hFF);
        send_write(MapperBase, 8'h01);
        send_write(16'hFFFF, 8'h80);
        send_load(16'h8000, 5'h1F, 1'b0);
        send_load(16'hA000, 5'h1F, 1'b0);
        send_load(16'hDFFF, 5'h15, 1'b0);
        send_load(16'hFFFF, 5'h0F, 1'b0);

        for (int p = 0; p < PhaseCount; p++) begin
            // Configuration for this phase; the first keeps the reset values.
            cfg_present = 1'b0;
            cfg_count   = sbm_pkg::PrgCountOuter;
            case (p)
                2: cfg_present = 1'b1;
                3: cfg_count   = 6'd2;
                4: cfg_count   = 6'($urandom_range(0, 63));
                5: begin
                    cfg_present = 1'b1;
                    cfg_count   = 6'd63;
                end
                6: cfg_count   = 6'd0;
                default: ;
            endcase
            if (p != 0) apply_settings(cfg_present, cfg_count);

            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase

            sent = 0;
            while (sent < PhaseItems) begin
                if ($urandom_range(0, 199) == 0) drain_results();
                kind = $urandom_range(0, 99);
                if (kind < 70) begin
                    // Well-formed load with random content and target.
                    addr = {1'b1, 2'($urandom_range(0, 3)), 13'($urandom_range(0, 8191))};
                    send_load(addr, 5'($urandom_range(0, 31)), 1'b1);
                    sent += 5;
                end else if (kind < 80) begin
                    addr = MapperBase | 16'($urandom_range(0, 16'h7FFF));
                    data = 8'h80 | 8'($urandom_range(0, 127));
                    send_write(addr, data);
                    sent++;
                end else if (kind < 90) begin
                    send_write(16'($urandom_range(0, 16'h7FFF)), 8'($urandom_range(0, 255)));
                end else begin
                    addr = 16'($urandom_range(0, 16'hFFFF));
                    send_write(addr, 8'($urandom_range(0, 255)));
                    if (addr >= MapperBase) sent++;
                end
            end
        end

        drain_results();
        repeat (TailCycles) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("serial_bank_mapper_top_test: clean");
        end else begin
            $display("serial_bank_mapper_top_test: errors");
        end
        $finish;
    end

endmodule
